/* design/stack_machine_executor_unit_assert.svh */
// Assertion macros for the stack machine executor.
// Define NO_ASSERTIONS to compile them away.
`ifndef STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SME_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SME_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SME_ASSERT_IMP(label, clk, rst, ante, cons)
`define SME_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/sme_pkg.sv */
// Package for the stack machine executor: types, opcodes, status codes.
// No dependencies.
package sme_pkg;
   localparam int OperandDepthDefault = 64;
   localparam int DataDepthDefault = 64;
   localparam int MaxResults = 64;
   localparam int QueueDepth = 2;

   localparam logic [1:0] REQ_PRELOAD = 2'd0;
   localparam logic [1:0] REQ_EXEC    = 2'd1;
   localparam logic [1:0] REQ_DRAIN   = 2'd2;
   localparam logic [1:0] REQ_CLEAR   = 2'd3;

   localparam logic [31:0] OP_PUSH = 32'h0000_2A3D;
   localparam logic [31:0] OP_POP  = 32'h00FF_FF28;
   localparam logic [31:0] OP_ADD  = 32'h0000_0000;
   localparam logic [31:0] OP_SUB  = 32'h0001_1111;
   localparam logic [31:0] OP_MUL  = 32'h000A_BCEF;
   localparam logic [31:0] OP_DIV  = 32'h0000_0514;
   localparam logic [31:0] OP_LOAD = 32'hFFFF_FFFF;
   localparam logic [31:0] OP_SAVE = 32'h1010_1010;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BADOP = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;
   localparam logic [2:0] ST_DIVZ  = 3'd5;
   localparam logic [2:0] ST_HALT  = 3'd6;

   typedef enum logic [3:0] {
      K_NONE = 4'b0000, K_BAD = 4'b0001, K_PUSH = 4'b0010, K_POP = 4'b0011,
      K_ADD = 4'b0100, K_SUB = 4'b0101, K_MUL = 4'b0110, K_DIV = 4'b0111,
      K_LOAD = 4'b1000, K_SAVE = 4'b1001
   } kind_type;

   typedef struct packed {
      logic [1:0]  req;
      kind_type    kind;
      logic [31:0] word;
   } cmd_type;

   function automatic kind_type classify(input logic [31:0] w);
      kind_type k;
      case (w)
         OP_PUSH: k = K_PUSH;
         OP_POP:  k = K_POP;
         OP_ADD:  k = K_ADD;
         OP_SUB:  k = K_SUB;
         OP_MUL:  k = K_MUL;
         OP_DIV:  k = K_DIV;
         OP_LOAD: k = K_LOAD;
         OP_SAVE: k = K_SAVE;
         default: k = K_BAD;
      endcase
      return k;
   endfunction
endpackage

/* design/sme_req_if.sv */
// Request and response channel interfaces.
// Depends on nothing.
interface sme_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] word;
   modport source (output valid, req_type, word, input ready);
   modport sink (input valid, req_type, word, output ready);
endinterface

interface sme_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] value;
   logic        last;
   modport source (output valid, status, value, last, input ready);
   modport sink (input valid, status, value, last, output ready);
endinterface

/* design/sme_front.sv */
// Front end: accepts request words, decodes opcodes, queues commands.
// Depends on sme_pkg.
module sme_front import sme_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   sme_req_if.sink req,
   output cmd_type cmd,
   output logic    cmd_valid,
   input  logic    cmd_take
);
   localparam int AW = $clog2(QueueDepth);
   cmd_type            q_ff [QueueDepth];
   logic [AW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               push, pop;

   assign req.ready = (cnt_ff != (AW+1)'(QueueDepth));
   assign push = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign pop = cmd_valid && cmd_take;
   assign cmd = q_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= '{req: req.req_type, kind: classify(req.word), word: req.word};
      end
   end
endmodule

/* design/sme_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on sme_pkg.
module sme_div import sme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] x,
   input  logic [31:0] y,
   output logic        done,
   output logic [31:0] q
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   assign done = busy_ff && (cnt_ff == 6'd1);
   assign q = neg_ff ? 32'd0 - quo_in : quo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= 6'd32;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      if (start) begin
         rem_ff <= '0;
         quo_ff <= x[31] ? 32'd0 - x : x;
         den_ff <= y[31] ? 32'd0 - y : y;
         neg_ff <= x[31] ^ y[31];
      end else begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end
endmodule

/* design/sme_back.sv */
// Back end: executes queued commands against the two stack memories.
// Depends on sme_pkg, sme_div, the assertion macro header.
`include "stack_machine_executor_unit_assert.svh"
module sme_back import sme_pkg::*; #(
   parameter int OPERAND_DEPTH = OperandDepthDefault,
   parameter int DATA_DEPTH = DataDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  logic     cmd_valid,
   output logic     cmd_take,
   sme_rsp_if.source rsp
);
   localparam int OW = $clog2(OPERAND_DEPTH);
   localparam int DW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int OC = $clog2(OPERAND_DEPTH + 1);
   localparam int DC = $clog2(DATA_DEPTH + 1);
   localparam int DrainMax = (DATA_DEPTH < MaxResults) ? DATA_DEPTH : MaxResults;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_RD1 = 7'b0000010, S_RD2 = 7'b0000100,
      S_EXE = 7'b0001000, S_DIVW = 7'b0010000, S_OUT = 7'b0100000,
      S_DRN = 7'b1000000
   } state_type;

   logic [31:0] ostore [OPERAND_DEPTH];
   logic [31:0] dstore [DATA_DEPTH];
   state_type   st_ff, st_in;
   logic [OC-1:0] on_ff, on_in;
   logic [DC-1:0] dn_ff, dn_in;
   logic        fault_ff, fault_in;
   logic [31:0] ord_ff, drd_ff, a_ff, b_ff;
   logic [OW-1:0] ora;
   logic [DW-1:0] dra;
   logic        o_we, d_we;
   logic [OW-1:0] owa;
   logic [DW-1:0] dwa;
   logic [31:0] owd, dwd;
   logic        ov_ff, ol_ff;
   logic [2:0]  os_ff;
   logic [31:0] oval_ff;
   logic [DC-1:0] di_ff, dcnt_ff;
   logic        drn_rd_ff, drn_last;
   logic        div_start, div_done;
   logic [31:0] div_q;
   logic signed [OC+1:0] idx;
   logic [63:0] prod;
   logic [31:0] alu;
   logic        out_free;
   logic [2:0]  rs_ff, rs_in;
   logic [31:0] rv_ff, rv_in;

   sme_div u_div (.clock(clock), .reset(reset), .start(div_start), .x(a_ff), .y(b_ff),
                  .done(div_done), .q(div_q));

   assign out_free = !ov_ff || rsp.ready;
   assign rsp.valid = ov_ff;
   assign rsp.status = os_ff;
   assign rsp.value = oval_ff;
   assign rsp.last = ol_ff;
   assign prod = a_ff * b_ff;
   assign alu = (cmd.kind == K_ADD) ? a_ff + b_ff :
                (cmd.kind == K_SUB) ? a_ff - b_ff : prod[31:0];
   assign drn_last = (di_ff + 1'b1 == dcnt_ff);

   // signed index for load/save: count-2 (or -3) + offset
   always_comb begin
      if (cmd.kind == K_LOAD)
         idx = (OC+2)'($signed({2'b0, on_ff}) - 2 + $signed(a_ff[OC+1:0]));
      else
         idx = (OC+2)'($signed({2'b0, on_ff}) - 3 + $signed(a_ff[OC+1:0]));
   end
   logic off_big;
   assign off_big = ($signed(a_ff) > $signed(32'(OPERAND_DEPTH + 4))) ||
                    ($signed(a_ff) < -$signed(32'(OPERAND_DEPTH + 4)));

   // top in S_IDLE, next in S_RD1, load target in S_RD2; data top, but drain index in S_DRN
   always_comb begin
      ora = '0;
      dra = DW'(dn_ff - 1'b1);
      case (st_ff)
         S_IDLE: ora = OW'(on_ff - 1'b1);
         S_RD1: ora = OW'(on_ff - 2'd2);
         S_RD2: if (cmd.kind == K_LOAD) ora = OW'(idx);
         S_DRN: dra = DW'(di_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      ord_ff <= ostore[ora];
      drd_ff <= dstore[dra];
      if (o_we) ostore[owa] <= owd;
      if (d_we) dstore[dwa] <= dwd;
   end

   always_comb begin
      st_in = st_ff;
      cmd_take = 1'b0;
      o_we = 1'b0; owa = '0; owd = '0;
      d_we = 1'b0; dwa = '0; dwd = '0;
      div_start = 1'b0;
      on_in = on_ff;
      dn_in = dn_ff;
      fault_in = fault_ff;
      rs_in = rs_ff;
      rv_in = rv_ff;
      case (st_ff)
         S_IDLE: if (cmd_valid) st_in = S_RD1;
         S_RD1: st_in = S_RD2;
         S_RD2: st_in = S_EXE;
         S_EXE: begin
            rs_in = ST_OK;
            rv_in = 32'd0;
            st_in = S_OUT;
            case (cmd.req)
               REQ_PRELOAD:
                  if (dn_ff >= DC'(DATA_DEPTH)) rs_in = ST_OVER;
                  else begin
                     d_we = 1'b1;
                     dwa = DW'(dn_ff);
                     dwd = cmd.word;
                     dn_in = dn_ff + 1'b1;
                     rv_in = cmd.word;
                  end
               REQ_CLEAR: begin
                  on_in = '0;
                  dn_in = '0;
                  fault_in = 1'b0;
               end
               REQ_DRAIN:
                  if (fault_ff || dn_ff == '0) rs_in = ST_HALT;
                  else st_in = S_DRN;
               default:
                  if (fault_ff) rs_in = ST_HALT;
                  else begin
                     case (cmd.kind)
                        K_PUSH:
                           if (dn_ff == '0) rs_in = ST_UNDER;
                           else if (on_ff >= OC'(OPERAND_DEPTH)) rs_in = ST_OVER;
                           else begin
                              o_we = 1'b1;
                              owa = OW'(on_ff);
                              owd = drd_ff;
                              on_in = on_ff + 1'b1;
                              dn_in = dn_ff - 1'b1;
                              rv_in = drd_ff;
                           end
                        K_POP:
                           if (on_ff == '0) rs_in = ST_UNDER;
                           else if (dn_ff >= DC'(DATA_DEPTH)) rs_in = ST_OVER;
                           else begin
                              d_we = 1'b1;
                              dwa = DW'(dn_ff);
                              dwd = a_ff;
                              dn_in = dn_ff + 1'b1;
                              on_in = on_ff - 1'b1;
                              rv_in = a_ff;
                           end
                        K_ADD, K_SUB, K_MUL:
                           if (on_ff < 2) rs_in = ST_UNDER;
                           else begin
                              o_we = 1'b1;
                              owa = OW'(on_ff - 2'd2);
                              owd = alu;
                              on_in = on_ff - 1'b1;
                              rv_in = alu;
                           end
                        K_DIV:
                           if (on_ff < 2) rs_in = ST_UNDER;
                           else if (b_ff == '0) rs_in = ST_DIVZ;
                           else begin
                              div_start = 1'b1;
                              st_in = S_DIVW;
                           end
                        K_LOAD:
                           if (on_ff < 1) rs_in = ST_UNDER;
                           else if (off_big || idx < 0 ||
                                    idx > $signed({2'b0, on_ff}) - 2) rs_in = ST_RANGE;
                           else begin
                              o_we = 1'b1;
                              owa = OW'(on_ff - 1'b1);
                              owd = ord_ff;
                              rv_in = ord_ff;
                           end
                        K_SAVE:
                           if (on_ff < 2) rs_in = ST_UNDER;
                           else if (off_big || idx < 0 ||
                                    idx > $signed({2'b0, on_ff}) - 3) rs_in = ST_RANGE;
                           else begin
                              o_we = 1'b1;
                              owa = OW'(idx);
                              owd = b_ff;
                              on_in = on_ff - 2'd2;
                              rv_in = b_ff;
                           end
                        default: rs_in = ST_BADOP;
                     endcase
                  end
            endcase
         end
         S_DIVW: if (div_done) begin
            o_we = 1'b1;
            owa = OW'(on_ff - 2'd2);
            owd = div_q;
            on_in = on_ff - 1'b1;
            rv_in = div_q;
            st_in = S_OUT;
         end
         S_OUT: if (out_free) begin
            cmd_take = 1'b1;
            if (cmd.req == REQ_EXEC && rs_ff != ST_OK && rs_ff != ST_HALT)
               fault_in = 1'b1;
            st_in = S_IDLE;
         end
         S_DRN: if (drn_rd_ff && out_free && drn_last) begin
            cmd_take = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // sequencing and result word, registered
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         on_ff <= '0;
         dn_ff <= '0;
         fault_ff <= 1'b0;
         ov_ff <= 1'b0;
         di_ff <= '0;
         drn_rd_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         on_ff <= on_in;
         dn_ff <= dn_in;
         fault_ff <= fault_in;
         rs_ff <= rs_in;
         rv_ff <= rv_in;
         if (st_ff == S_RD1) a_ff <= ord_ff;
         if (st_ff == S_RD2) b_ff <= ord_ff;
         if (st_ff == S_EXE) begin
            di_ff <= '0;
            dcnt_ff <= (dn_ff < DC'(DrainMax)) ? dn_ff : DC'(DrainMax);
            drn_rd_ff <= 1'b0;
         end else if (st_ff == S_DRN) begin
            if (!drn_rd_ff) drn_rd_ff <= 1'b1;
            else if (out_free) begin
               drn_rd_ff <= 1'b0;
               if (!drn_last) di_ff <= di_ff + 1'b1;
            end
         end
         if ((st_ff == S_OUT || (st_ff == S_DRN && drn_rd_ff)) && out_free) begin
            ov_ff <= 1'b1;
            if (st_ff == S_OUT) begin
               os_ff <= rs_ff;
               oval_ff <= (rs_ff == ST_OK) ? rv_ff : 32'd0;
               ol_ff <= 1'b1;
            end else begin
               os_ff <= ST_OK;
               oval_ff <= drd_ff;
               ol_ff <= drn_last;
            end
         end else if (rsp.ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   `SME_ASSERT_NXT(a_div_done, clock, reset, div_start, st_ff == S_DIVW)
   `SME_ASSERT_IMP(a_on_rng, clock, reset, 1'b1, on_ff <= OC'(OPERAND_DEPTH))
   `SME_ASSERT_IMP(a_dn_rng, clock, reset, 1'b1, dn_ff <= DC'(DATA_DEPTH))
endmodule

/* design/stack_machine_executor_unit.sv */
// Two-stack machine executor. One item at a time in the back end: each item passes
// dispatch, two operand reads, execute and result, in that order; division waits on the
// iterative divider; drain reads each word, then emits it.
// A stalled result holds the back end in its result state.
// Synchronous active-high reset clears stack counts, fault flag and queue;
// stack memories are not cleared.
module stack_machine_executor_unit import sme_pkg::*; #(
   parameter int OPERAND_DEPTH = OperandDepthDefault,
   parameter int DATA_DEPTH = DataDepthDefault
) (
   input logic       clock,
   input logic       reset,
   sme_req_if.sink   req,
   sme_rsp_if.source rsp
);
   cmd_type cmd;
   logic    cmd_valid, cmd_take;

   sme_front u_front (.clock(clock), .reset(reset), .req(req), .cmd(cmd),
                      .cmd_valid(cmd_valid), .cmd_take(cmd_take));

   sme_back #(.OPERAND_DEPTH(OPERAND_DEPTH), .DATA_DEPTH(DATA_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .rsp(rsp));
endmodule
